### sv/sorted_priority_queue_top_macros.svh
// ----------------------------------------------------------------------------
// sorted_priority_queue_top_macros.svh
// Assertion macros used by the checker file of the sorted priority queue.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk and quiet during reset.
`define SPQ_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sorted priority queue: assertion failed");

// Next-cycle implication, sampled on clk and quiet during reset.
`define SPQ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sorted priority queue: assertion failed");

`endif

### sv/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Types and codes shared by the sorted priority queue modules.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

	// Field widths of one item and one result.
	localparam int ID_W      = 16;
	localparam int PRIO_W    = 16;
	localparam int STATUS_W  = 2;
	localparam int OUT_CNT_W = 11;

	// Operation codes.
	localparam logic OP_ENQ = 1'b0;
	localparam logic OP_DEQ = 1'b1;

	// Status codes.
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	// One stored entry.
	typedef struct packed {
		logic [PRIO_W-1:0] prio;
		logic [ID_W-1:0]   id;
	} entry_t;

	// Command broadcast to every cell of the chain.
	typedef struct packed {
		logic   enq;
		logic   deq;
		entry_t ent;
	} cell_ctrl_t;

endpackage

`default_nettype wire

### sv/spq_if.sv
// ----------------------------------------------------------------------------
// spq_if
// Valid/ready channels carrying commands into and results out of the queue.
// ----------------------------------------------------------------------------
`default_nettype none

// Command channel: one item is an enqueue or a dequeue.
interface spq_cmd_if import spq_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              op;
	logic [ID_W-1:0]   entry_id;
	logic [PRIO_W-1:0] entry_priority;

	modport source (output valid, output op, output entry_id, output entry_priority,
		input ready);
	modport sink (input valid, input op, input entry_id, input entry_priority,
		output ready);
endinterface

// Result channel: one item per accepted command.
interface spq_rsp_if import spq_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [STATUS_W-1:0]  status;
	logic [ID_W-1:0]      out_id;
	logic [PRIO_W-1:0]    out_priority;
	logic [OUT_CNT_W-1:0] comparisons;
	logic [OUT_CNT_W-1:0] occupancy;

	modport source (output valid, output status, output out_id, output out_priority,
		output comparisons, output occupancy, input ready);
	modport sink (input valid, input status, input out_id, input out_priority,
		input comparisons, input occupancy, output ready);
endinterface

`default_nettype wire

### sv/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds an entry, compares it with the
// incoming priority and shifts towards or away from the head of the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell import spq_pkg::*; #(
	parameter int CNT_W = 11,
	parameter int INDEX = 0
) (
	input  wire logic             clk,
	input  wire cell_ctrl_t       ctrl,
	input  wire logic [CNT_W-1:0] fill,
	input  wire logic             prev_keep,
	input  wire entry_t           prev_ent,
	input  wire entry_t           next_ent,
	output entry_t                ent,
	output logic                  keep,
	output logic                  ins
);

	entry_t ent_q;
	logic   occupied;

	// The slot holds a live entry when it lies below the fill count.
	assign occupied = (fill > CNT_W'(INDEX));

	// An entry of equal or higher priority stays where it is on an enqueue.
	assign keep = occupied && (ent_q.prio >= ctrl.ent.prio);

	// The new entry lands in the first slot that does not keep its entry.
	assign ins = prev_keep && !keep;

	// Insert, shift away from the head, or shift towards the head.
	always_ff @(posedge clk) begin
		if (ctrl.enq) begin
			if (!keep) begin
				ent_q <= prev_keep ? ctrl.ent : prev_ent;
			end
		end else if (ctrl.deq) begin
			ent_q <= next_ent;
		end
	end

	assign ent = ent_q;

endmodule

`default_nettype wire

### sv/spq_enc.sv
// ----------------------------------------------------------------------------
// spq_enc
// One-hot to binary encoder that turns the insertion marks of the chain
// into the slot number of the new entry.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_enc #(
	parameter int N = 1024,
	parameter int W = 10
) (
	input  wire logic [N-1:0] onehot,
	output logic [W-1:0]      idx
);

	// Each index bit is the OR of the marks whose slot number has it set.
	always_comb begin
		idx = '0;
		for (int i = 0; i < N; i++) begin
			if (onehot[i]) begin
				idx = idx | W'(i);
			end
		end
	end

endmodule

`default_nettype wire

### sv/sorted_priority_queue_top.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_top
// Priority queue kept as a chain of cells sorted by descending priority;
// equal priorities leave in arrival order.
// ----------------------------------------------------------------------------
//
//  Channel  Role  Payload
//  -------  ----  ---------------------------------------------------------
//  cmd      sink  op, entry_id, entry_priority
//  rsp      src   status, out_id, out_priority, comparisons, occupancy
//
//  One item per cycle while rsp does not stall: every cell compares and shifts in the accept cycle.
//  A result passes the first result stage and the output register; the insertion
//  slot is encoded from the marks of the cells registered in the first stage.
//  arst_n empties the queue at once by clearing the fill count.
//  A stalled rsp holds the output register, and the first stage once it is full; cmd then waits with them.
//
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue_top import spq_pkg::*; #(
	parameter int DEPTH = 1024
) (
	input  wire logic clk,
	input  wire logic arst_n,
	spq_cmd_if.sink   cmd,
	spq_rsp_if.source rsp
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CW    = (CNT_W + 1 > OUT_CNT_W) ? CNT_W + 1 : OUT_CNT_W;
	localparam int OW    = (CNT_W > OUT_CNT_W) ? CNT_W : OUT_CNT_W;

	logic [CNT_W-1:0] fill_q;
	logic             cmd_fire, is_deq, full, empty, enq_go, deq_go, adv_out;
	cell_ctrl_t       ctrl;
	entry_t           ent_w [DEPTH];
	logic [DEPTH-1:0] keep_w, ins_w;

	logic                valid_s1, is_enq_s1;
	logic [STATUS_W-1:0] status_s1;
	entry_t              deq_ent_s1;
	logic [CNT_W-1:0]    fill_after_s1;
	logic [DEPTH-1:0]    ins_s1;

	logic [IDX_W-1:0]     pos;
	logic [CW-1:0]        cmp_wide;
	logic [OW-1:0]        occ_wide;
	logic                 out_valid_q;
	logic [STATUS_W-1:0]  status_q;
	logic [ID_W-1:0]      out_id_q;
	logic [PRIO_W-1:0]    out_priority_q;
	logic [OUT_CNT_W-1:0] comparisons_q, occupancy_q;

	// Handshake and command decode.
	assign adv_out   = !out_valid_q || rsp.ready;
	assign cmd.ready = !valid_s1 || adv_out;
	assign cmd_fire  = cmd.valid && cmd.ready;
	assign is_deq    = (cmd.op == OP_DEQ);
	assign full      = (fill_q == CNT_W'(DEPTH));
	assign empty     = (fill_q == '0);
	assign enq_go    = cmd_fire && !is_deq && !full;
	assign deq_go    = cmd_fire && is_deq && !empty;

	assign ctrl.enq      = enq_go;
	assign ctrl.deq      = deq_go;
	assign ctrl.ent.prio = cmd.entry_priority;
	assign ctrl.ent.id   = cmd.entry_id;

	// Fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (enq_go) begin
			fill_q <= fill_q + CNT_W'(1);
		end else if (deq_go) begin
			fill_q <= fill_q - CNT_W'(1);
		end
	end

	// Chain of cells; slot zero is the head of the queue.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		entry_t prev_ent, next_ent;
		logic   prev_keep;

		if (i == 0) begin : g_head
			assign prev_ent  = ctrl.ent;
			assign prev_keep = 1'b1;
		end else begin : g_body
			assign prev_ent  = ent_w[i-1];
			assign prev_keep = keep_w[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign next_ent = ent_w[i];
		end else begin : g_link
			assign next_ent = ent_w[i+1];
		end

		spq_cell #(
			.CNT_W (CNT_W),
			.INDEX (i)
		) u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.fill      (fill_q),
			.prev_keep (prev_keep),
			.prev_ent  (prev_ent),
			.next_ent  (next_ent),
			.ent       (ent_w[i]),
			.keep      (keep_w[i]),
			.ins       (ins_w[i])
		);
	end

	// First result stage: control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	// First result stage: payload captured with the item.
	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			is_enq_s1 <= !is_deq;
			ins_s1    <= ins_w;
			if (!is_deq) begin
				status_s1     <= full ? ST_FULL : ST_OK;
				deq_ent_s1    <= '0;
				fill_after_s1 <= full ? fill_q : fill_q + CNT_W'(1);
			end else if (empty) begin
				status_s1     <= ST_EMPTY;
				deq_ent_s1    <= '0;
				fill_after_s1 <= '0;
			end else begin
				status_s1     <= ST_OK;
				deq_ent_s1    <= ent_w[0];
				fill_after_s1 <= fill_q - CNT_W'(1);
			end
		end
	end

	// Slot of the inserted entry.
	spq_enc #(
		.N (DEPTH),
		.W (IDX_W)
	) u_enc (
		.onehot (ins_s1),
		.idx    (pos)
	);

	// The entries of equal or higher priority ahead of the new slot count as moved.
	assign cmp_wide = CW'(pos) + CW'(1);
	assign occ_wide = OW'(fill_after_s1);

	// Output register: control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_out) begin
			out_valid_q <= valid_s1;
		end
	end

	// Output register: payload.
	always_ff @(posedge clk) begin
		if (adv_out && valid_s1) begin
			status_q       <= status_s1;
			out_id_q       <= deq_ent_s1.id;
			out_priority_q <= deq_ent_s1.prio;
			occupancy_q    <= occ_wide[OUT_CNT_W-1:0];
			if (is_enq_s1 && (status_s1 == ST_OK)) begin
				comparisons_q <= cmp_wide[OUT_CNT_W-1:0];
			end else if (is_enq_s1) begin
				comparisons_q <= OUT_CNT_W'(1);
			end else begin
				comparisons_q <= '0;
			end
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.status       = status_q;
	assign rsp.out_id       = out_id_q;
	assign rsp.out_priority = out_priority_q;
	assign rsp.comparisons  = comparisons_q;
	assign rsp.occupancy    = occupancy_q;

endmodule

`default_nettype wire

### sv/spq_checker.sv
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks on the results of the sorted priority queue, bound to
// the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_priority_queue_top_macros.svh"

module spq_checker import spq_pkg::*; (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 rsp_valid,
	input wire logic                 rsp_ready,
	input wire logic [STATUS_W-1:0]  rsp_status,
	input wire logic [ID_W-1:0]      rsp_out_id,
	input wire logic [PRIO_W-1:0]    rsp_out_priority,
	input wire logic [OUT_CNT_W-1:0] rsp_comparisons,
	input wire logic [OUT_CNT_W-1:0] rsp_occupancy
);

	// A result that is not taken stays offered.
	`SPQ_ASSERT_NEXT(a_rsp_held, rsp_valid && !rsp_ready, rsp_valid)

	// A dequeue from an empty queue reports nothing but its status.
	`SPQ_ASSERT_NOW(a_empty_zero, rsp_valid && (rsp_status == ST_EMPTY), (rsp_out_id == '0) && (rsp_out_priority == '0) && (rsp_comparisons == '0) && (rsp_occupancy == '0))

	// An enqueue into a full queue counts one comparison and returns no entry.
	`SPQ_ASSERT_NOW(a_full_one, rsp_valid && (rsp_status == ST_FULL), (rsp_comparisons == OUT_CNT_W'(1)) && (rsp_out_id == '0) && (rsp_out_priority == '0))

	// A successful enqueue carries comparisons and never a dequeued entry.
	`SPQ_ASSERT_NOW(a_enq_no_entry, rsp_valid && (rsp_status == ST_OK) && (rsp_comparisons != '0), (rsp_out_id == '0) && (rsp_out_priority == '0))

endmodule

bind sorted_priority_queue_top spq_checker u_spq_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_status       (rsp.status),
	.rsp_out_id       (rsp.out_id),
	.rsp_out_priority (rsp.out_priority),
	.rsp_comparisons  (rsp.comparisons),
	.rsp_occupancy    (rsp.occupancy)
);

`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sorted priority queue. A scoreboard mirrors
// the sorted store, predicts the result of every accepted command and
// compares each result field by field in order. The stimulus runs a short
// directed sequence and random traffic near empty, up to full and past it,
// churns near the top and drains most of it; both channels get random gaps.
// ----------------------------------------------------------------------------

module tb_top;
	import spq_pkg::*;

	localparam int DEPTH      = 1024;
	localparam int IDLE_LIMIT = 2000;

	// One result as seen on the rsp channel.
	typedef struct packed {
		logic [STATUS_W-1:0]  status;
		logic [ID_W-1:0]      out_id;
		logic [PRIO_W-1:0]    out_priority;
		logic [OUT_CNT_W-1:0] comparisons;
		logic [OUT_CNT_W-1:0] occupancy;
	} result_t;

	// Mirror of the queue: works out each result and checks what comes back.
	class queue_scoreboard;
		entry_t      store[DEPTH];
		int unsigned fill;
		result_t     due_results[$];
		int unsigned errors;

		function new();
			fill   = 0;
			errors = 0;
		endfunction

		task report(string msg);
			$display("%0t ns: mismatch: %s", $time, msg);
			errors++;
		endtask

		// Apply an accepted command to the mirror and queue its result.
		function void note_command(logic op, logic [ID_W-1:0] id, logic [PRIO_W-1:0] pr);
			result_t     r;
			int unsigned slot;
			int unsigned moved;
			r     = '0;
			moved = 0;
			if (op == OP_ENQ) begin
				if (fill >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					slot = fill;
					// Entries of equal or higher priority shift up one slot.
					while (slot > 0 && store[slot-1].prio >= pr) begin
						store[slot] = store[slot-1];
						slot--;
						moved++;
					end
					store[slot].prio = pr;
					store[slot].id   = id;
					fill++;
					r.status = ST_OK;
				end
				r.comparisons = OUT_CNT_W'(moved + 1);
				r.occupancy   = OUT_CNT_W'(fill);
			end else if (fill == 0) begin
				r.status = ST_EMPTY;
			end else begin
				fill--;
				r.status       = ST_OK;
				r.out_id       = store[fill].id;
				r.out_priority = store[fill].prio;
				r.occupancy    = OUT_CNT_W'(fill);
			end
			due_results.push_back(r);
		endfunction

		// Compare a result with the oldest one still due.
		task check_result(result_t got);
			result_t want;
			if (due_results.size() == 0) begin
				report("result arrived with none due");
			end else begin
				want = due_results.pop_front();
				if (got.status !== want.status)
					report($sformatf("status expected %0d, got %0d", want.status, got.status));
				if (got.out_id !== want.out_id)
					report($sformatf("out_id expected %0h, got %0h", want.out_id, got.out_id));
				if (got.out_priority !== want.out_priority)
					report($sformatf("out_priority expected %0h, got %0h",
						want.out_priority, got.out_priority));
				if (got.comparisons !== want.comparisons)
					report($sformatf("comparisons expected %0d, got %0d",
						want.comparisons, got.comparisons));
				if (got.occupancy !== want.occupancy)
					report($sformatf("occupancy expected %0d, got %0d",
						want.occupancy, got.occupancy));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;

	spq_cmd_if cmd_ch ();
	spq_rsp_if rsp_ch ();

	sorted_priority_queue_top #(
		.DEPTH(DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.rsp(rsp_ch)
	);

	queue_scoreboard board;
	result_t         seen_result;
	int              idle_cycles;
	int              stall_left;
	bit              cmd_calm;
	bit              rsp_calm;
	int              level;

	// Clock.
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Known values on every input from time zero.
	initial begin
		arst_n                = 1'b0;
		cmd_ch.valid          = 1'b0;
		cmd_ch.op             = OP_ENQ;
		cmd_ch.entry_id       = '0;
		cmd_ch.entry_priority = '0;
		rsp_ch.ready          = 1'b0;
		stall_left            = 0;
		idle_cycles           = 0;
		cmd_calm              = 1'b0;
		rsp_calm              = 1'b0;
		board                 = new();
	end

	// Result side back-pressure: mostly short stalls, now and then a long one.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			rsp_ch.ready <= 1'b0;
			stall_left   <= stall_left - 1;
		end else if (!rsp_calm && $urandom_range(0, 99) < 20) begin
			rsp_ch.ready <= 1'b0;
			if ($urandom_range(0, 9) == 0)
				stall_left <= $urandom_range(10, 40);
			else
				stall_left <= $urandom_range(0, 2);
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	// Monitor: check results first, then note the accepted command.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				seen_result.status       = rsp_ch.status;
				seen_result.out_id       = rsp_ch.out_id;
				seen_result.out_priority = rsp_ch.out_priority;
				seen_result.comparisons  = rsp_ch.comparisons;
				seen_result.occupancy    = rsp_ch.occupancy;
				board.check_result(seen_result);
			end
			if (cmd_ch.valid && cmd_ch.ready)
				board.note_command(cmd_ch.op, cmd_ch.entry_id, cmd_ch.entry_priority);
		end
	end

	// Watchdog: too long without any item moving ends the run.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb_top failed");
				$finish;
			end
		end
	end

	// Sender gap: mostly none or short, a few long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (cmd_calm || r < 60)
			return 0;
		else if (r < 93)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 40);
	endfunction

	// Priorities cluster on a few values so that ties are common.
	function automatic logic [PRIO_W-1:0] pick_prio();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return PRIO_W'($urandom_range(0, 7));
		else if (r == 4)
			return $urandom_range(0, 1) ? '1 : '0;
		else if (r == 5)
			return PRIO_W'(16'h8000 + $urandom_range(0, 3));
		else
			return PRIO_W'($urandom_range(0, 65535));
	endfunction

	// Drive one command and hold it until accepted. The valid is lowered
	// only when a gap comes first, so back-to-back items keep it high.
	task automatic send_cmd(logic op, logic [ID_W-1:0] id, logic [PRIO_W-1:0] pr, int gap);
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid          <= 1'b1;
		cmd_ch.op             <= op;
		cmd_ch.entry_id       <= id;
		cmd_ch.entry_priority <= pr;
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
		if (op == OP_ENQ && level < DEPTH)
			level++;
		else if (op == OP_DEQ && level > 0)
			level--;
	endtask

	// One random command; enq_pct is the chance of an enqueue.
	task automatic send_random(int enq_pct);
		logic op;
		op = ($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ;
		send_cmd(op, ID_W'($urandom_range(0, 65535)), pick_prio(), pick_gap());
	endtask

	// Stop sending and wait until every result due has come back.
	task automatic wait_drained();
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (board.due_results.size() > 0) @(posedge clk);
	endtask

	// Main sequence.
	initial begin
		level = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty dequeue, field extremes, ties and full shifts.
		send_cmd(OP_DEQ, '1, '1, 0);
		send_cmd(OP_ENQ, 16'h0000, 16'h0000, 0);
		send_cmd(OP_ENQ, 16'hFFFF, 16'hFFFF, 0);
		send_cmd(OP_ENQ, 16'h1234, 16'h8000, 1);
		send_cmd(OP_ENQ, 16'h0002, 16'h8000, 0);
		send_cmd(OP_ENQ, 16'h0003, 16'h8000, 0);
		send_cmd(OP_ENQ, 16'h0004, 16'h0000, 2);
		send_cmd(OP_ENQ, 16'h0005, 16'hFFFF, 0);
		send_cmd(OP_ENQ, 16'hAAAA, 16'h5555, 0);
		send_cmd(OP_ENQ, 16'h5555, 16'hAAAA, 0);
		repeat (10) send_cmd(OP_DEQ, 16'h0000, 16'h0000, $urandom_range(0, 1));
		send_cmd(OP_DEQ, 16'h0000, 16'h0000, 0);
		wait_drained();

		// Mixed traffic around an empty queue.
		level = board.fill;
		for (int i = 0; i < 150; i++) begin
			if (i % 50 == 0) begin
				cmd_calm = ($urandom_range(0, 3) == 0);
				rsp_calm = ($urandom_range(0, 3) == 0);
			end
			send_random(50);
		end
		wait_drained();

		// Fill up to full, then push past it.
		level = board.fill;
		for (int i = 0; level < DEPTH; i++) begin
			if (i % 100 == 0) begin
				cmd_calm = ($urandom_range(0, 3) == 0);
				rsp_calm = ($urandom_range(0, 3) == 0);
			end
			send_random(95);
		end
		repeat (8) send_cmd(OP_ENQ, ID_W'($urandom_range(0, 65535)), pick_prio(), pick_gap());

		// Churn near the top, then drain most of the way.
		for (int i = 0; i < 100; i++)
			send_random(60);
		for (int i = 0; i < 300; i++) begin
			if (i % 100 == 0) begin
				cmd_calm = ($urandom_range(0, 3) == 0);
				rsp_calm = ($urandom_range(0, 3) == 0);
			end
			send_random(15);
		end

		// Let everything come back, plus a margin for stray results.
		wait_drained();
		rsp_calm = 1'b0;
		repeat (10) @(posedge clk);
		if (board.due_results.size() > 0)
			board.report($sformatf("%0d results never arrived", board.due_results.size()));
		if (board.errors == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
